// ===== src/lir_pkg.sv =====
// Shared constants and types for the linear interpolation resampler.
`timescale 1ns / 1ps
`default_nettype none

package lir_pkg;

  // Fixed-point format of phase and step
  localparam int FRAC_BITS      = 16;
  localparam int MAX_OUT_PER_IN = 8;
  localparam int PHASE_W        = FRAC_BITS + 6;
  localparam int STEP_W         = 20;
  localparam int SAMPLE_W       = 16;
  localparam int DIFF_W         = SAMPLE_W + 1;
  localparam int PROD_W         = DIFF_W + FRAC_BITS;
  localparam int CNT_W          = $clog2(MAX_OUT_PER_IN + 1);
  localparam int BIT_W          = $clog2(FRAC_BITS);

  // Configuration port
  localparam int                 PADDR_W    = 3;
  localparam int                 PDATA_W    = 32;
  localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(196608);
  localparam logic               REG_STEP   = 1'b0;  // word index of step_ratio

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [DIFF_W-1:0]   diff_t;
  typedef logic signed [PROD_W-1:0]   prod_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_EMIT
  } lir_state_e;

endpackage

`default_nettype wire

// ===== src/lir_if.sv =====
// Valid/ready channel interfaces for input and result items.
`timescale 1ns / 1ps
`default_nettype none

interface lir_in_if;
  import lir_pkg::*;
  logic    valid;
  logic    ready;
  sample_t in_sample;
  logic    silent;

  modport source (output valid, output in_sample, output silent, input ready);
  modport sink   (input valid, input in_sample, input silent, output ready);
endinterface

interface lir_out_if;
  import lir_pkg::*;
  logic    valid;
  logic    ready;
  sample_t out_sample;
  logic    last;

  modport source (output valid, output out_sample, output last, input ready);
  modport sink   (input valid, input out_sample, input last, output ready);
endinterface

`default_nettype wire

// ===== src/linear_interp_resampler.sv =====
// Top level of the linear interpolation resampler to the 16 kHz output rate.
//
// Usage: input items (in_sample, silent) arrive on in_i, results
// (out_sample, last) leave on out_o; both are valid/ready channels.
// step_ratio (input rate / 16000, 16 fraction bits) is written through the
// APB-style port at byte address 0 and read back there; write it while idle.
// The first item after reset is only stored and gives no result. Each later
// item gives zero to eight results; last marks the final one of an item.
// Sequence: an item is accepted in the idle state; then each result passes
// a check step, the bit-serial multiplier, a step to register its product
// and an emit step, and a closing check step ends the item.
// Results go to an output register: the next item is accepted while the
// final result still waits, but a stalled receiver holds the emit step of
// any further result until the register frees.
// Reset clears the phase, the stored sample and the step to 3.0.
`timescale 1ns / 1ps
`default_nettype none

module linear_interp_resampler
  import lir_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  lir_in_if.sink                  in_i,
  lir_out_if.source               out_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  lir_state_e           state_q, state_d;
  logic [STEP_W-1:0]    step_q;
  logic                 have_prev_q;
  sample_t              prev_q;
  sample_t              cur_q;
  diff_t                diff_q;
  logic [PHASE_W-1:0]   phase_q;
  logic [CNT_W-1:0]     count_q;
  logic                 out_valid_q;
  sample_t              out_sample_q;
  logic                 out_last_q;

  logic                 in_fire;
  logic                 cfg_wr;
  sample_t              cur_in;
  logic                 phase_lt_one;
  logic                 more;
  logic [PHASE_W-1:0]   phase_next;
  logic                 out_free;
  logic                 mul_start;
  logic                 mul_done;
  prod_t                mul_prod;
  logic signed [PROD_W:0] num;
  logic signed [PROD_W-FRAC_BITS:0] quo;
  logic                 emit_go;
  logic                 in_ready;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_STEP);
  assign prdata = (paddr[PADDR_W-1] == REG_STEP) ? PDATA_W'(step_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_RESET;
    end else if (cfg_wr) begin
      step_q <= pwdata[STEP_W-1:0];
    end
  end

  // Loop condition and interpolation result
  assign in_fire      = in_i.valid && in_ready;
  assign cur_in       = in_i.silent ? sample_t'(0) : in_i.in_sample;
  assign phase_lt_one = (phase_q[PHASE_W-1:FRAC_BITS] == '0);
  assign more         = phase_lt_one && (count_q < CNT_W'(MAX_OUT_PER_IN));
  assign phase_next   = phase_q + PHASE_W'(step_q);
  assign out_free     = !out_valid_q || out_o.ready;
  assign num          = ($signed({prev_q, {FRAC_BITS{1'b0}}}) + (PROD_W+1)'(0))
                      + (PROD_W+1)'(mul_prod);
  // Truncate toward zero: round negative values with a fraction up
  assign quo          = num[PROD_W:FRAC_BITS]
                      + (PROD_W-FRAC_BITS+1)'(num[PROD_W] && (|num[FRAC_BITS-1:0]));

  lir_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (diff_q),
    .mplier_i (phase_q[FRAC_BITS-1:0]),
    .done_o   (mul_done),
    .prod_o   (mul_prod)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_fire && have_prev_q) state_d = ST_CHECK;
      ST_CHECK: state_d = more ? ST_MUL : ST_IDLE;
      ST_MUL:   if (mul_done) state_d = ST_EMIT;
      ST_EMIT:  if (out_free) state_d = ST_CHECK;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready  = 1'b0;
    mul_start = 1'b0;
    emit_go   = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_ready  = 1'b1;
      ST_CHECK: mul_start = more;
      ST_MUL:   ;
      ST_EMIT:  emit_go   = out_free;
      default:  ;
    endcase
  end

  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      have_prev_q <= 1'b0;
      prev_q      <= '0;
      phase_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // Load a new result, or drop the held one once taken
      if (emit_go) begin
        out_valid_q <= 1'b1;
        phase_q     <= phase_next;
        count_q     <= count_q + CNT_W'(1);
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      // Store the first item, or start the loop over a later one
      if (in_fire) begin
        count_q <= '0;
        if (!have_prev_q) begin
          have_prev_q <= 1'b1;
          prev_q      <= cur_in;
        end
      end
      // Close the loop: reduce the phase by one (clear it if below one) and advance the sample
      if (state_q == ST_CHECK && !more) begin
        phase_q <= phase_lt_one ? '0 : phase_q - PHASE_W'(1 << FRAC_BITS);
        prev_q  <= cur_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cur_q  <= cur_in;
      diff_q <= DIFF_W'(cur_in) - DIFF_W'(prev_q);
    end
    if (emit_go) begin
      out_sample_q <= quo[SAMPLE_W-1:0];
      out_last_q   <= (phase_next[PHASE_W-1:FRAC_BITS] != '0)
                   || (count_q == CNT_W'(MAX_OUT_PER_IN - 1));
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_sample = out_sample_q;
  assign out_o.last       = out_last_q;

endmodule

`default_nettype wire

// ===== src/lir_mul.sv =====
// Bit-serial signed by unsigned multiplier, one multiplier bit per cycle, MSB first.
`timescale 1ns / 1ps
`default_nettype none

module lir_mul
  import lir_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire diff_t                mcand_i,
  input  wire logic [FRAC_BITS-1:0] mplier_i,
  output logic                      done_o,
  output prod_t                     prod_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [BIT_W-1:0]     bit_q, bit_d;
  logic [FRAC_BITS-1:0] mplier_q, mplier_d;
  diff_t                mcand_q, mcand_d;
  prod_t                acc_q, acc_d;

  // Shift the product left and add the multiplicand for each set bit
  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    bit_d    = bit_q;
    mplier_d = mplier_q;
    mcand_d  = mcand_q;
    acc_d    = acc_q;
    if (start_i) begin
      busy_d   = 1'b1;
      bit_d    = '0;
      mplier_d = mplier_i;
      mcand_d  = mcand_i;
      acc_d    = '0;
    end else if (busy_q) begin
      acc_d    = (acc_q <<< 1)
               + (mplier_q[FRAC_BITS-1] ? PROD_W'(mcand_q) : prod_t'(0));
      mplier_d = mplier_q << 1;
      bit_d    = bit_q + BIT_W'(1);
      if (bit_q == BIT_W'(FRAC_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      bit_q  <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mplier_q <= mplier_d;
    mcand_q  <= mcand_d;
    acc_q    <= acc_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire
